// File: src/acfb_pkg.sv
// Shared types, CRC byte step and sequencer microcode for the arm command frame builder.
// No dependencies; imported by acfb_crc and arm_command_frame_builder.
package acfb_pkg;

    // frame geometry
    localparam int unsigned FRAME_LEN   = 45;
    localparam int unsigned STEP_W      = 6;
    localparam logic [7:0]  CRC_EXTRA   = 8'd152;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    // register indexes on the config port
    localparam logic REG_SYSID  = 1'b0;
    localparam logic REG_COMPID = 1'b1;

    // byte source selected by a microcode word
    typedef enum logic [2:0] {
        SRC_LIT,
        SRC_SEQ,
        SRC_SYSID,
        SRC_COMPID,
        SRC_ARM,
        SRC_FORCE,
        SRC_CRC_LO,
        SRC_CRC_HI
    } src_t;

    // CRC unit control
    typedef struct packed {
        logic init;   // load CRC_INIT
        logic en;     // fold in the current byte
        logic extra;  // also fold in CRC_EXTRA after the byte
    } crc_ctl_t;

    // one microcode word
    typedef struct packed {
        src_t       src;
        logic [7:0] lit;
        crc_ctl_t   crc;
        logic       fin;  // end of program: emit as last byte, return to step 0
    } uword_t;

    // CRC-16/MCRF4XX, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ acc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

    // microcode ROM: one word per frame byte
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w.src       = SRC_LIT;
        w.lit       = 8'h00;
        w.crc.init  = 1'b0;
        w.crc.en    = 1'b1;
        w.crc.extra = 1'b0;
        w.fin       = 1'b0;
        case (step)
            6'd0: begin
                w.lit      = 8'hFD;
                w.crc.init = 1'b1;
                w.crc.en   = 1'b0;
            end
            6'd1:  w.lit = 8'd33;
            6'd4:  w.src = SRC_SEQ;
            6'd5:  w.src = SRC_SYSID;
            6'd6:  w.src = SRC_COMPID;
            6'd7:  w.lit = 8'd76;
            // param1 = 1.0f when arming
            6'd12: begin
                w.src = SRC_ARM;
                w.lit = 8'h80;
            end
            6'd13: begin
                w.src = SRC_ARM;
                w.lit = 8'h3F;
            end
            // param2 = 21196.0f when forcing
            6'd15: begin
                w.src = SRC_FORCE;
                w.lit = 8'h98;
            end
            6'd16: begin
                w.src = SRC_FORCE;
                w.lit = 8'hA5;
            end
            6'd17: begin
                w.src = SRC_FORCE;
                w.lit = 8'h46;
            end
            // command 400, target system and component
            6'd38: w.lit = 8'd144;
            6'd39: w.lit = 8'd1;
            6'd40: w.lit = 8'd1;
            6'd41: w.lit = 8'd1;
            // last payload byte, then the message's extra CRC byte
            6'd42: w.crc.extra = 1'b1;
            6'd43: begin
                w.src    = SRC_CRC_LO;
                w.crc.en = 1'b0;
            end
            6'd44: begin
                w.src    = SRC_CRC_HI;
                w.crc.en = 1'b0;
                w.fin    = 1'b1;
            end
            default: w.lit = 8'h00;
        endcase
        return w;
    endfunction

endpackage

// File: src/acfb_crc.sv
// Running CRC-16/MCRF4XX accumulator, up to two byte steps per cycle.
// Depends on acfb_pkg (crc_ctl_t, crc_step, CRC_INIT, CRC_EXTRA).
module acfb_crc (
    input  logic              aclk,
    input  logic              aresetn,
    input  acfb_pkg::crc_ctl_t ctl,
    input  logic [7:0]        data,
    output logic [15:0]       crc
);
    import acfb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_byte;

    // byte step, then optional extra byte
    always_comb begin
        crc_byte = crc_step(crc_reg, data);
        crc_next = crc_reg;
        if (ctl.init) begin
            crc_next = CRC_INIT;
        end else if (ctl.en) begin
            crc_next = ctl.extra ? crc_step(crc_byte, CRC_EXTRA) : crc_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// File: src/arm_command_frame_builder.sv
// Top level: APB config registers, microcoded byte sequencer and output register.
// Depends on acfb_pkg and acfb_crc.
// An accepted request is registered in busy_reg and the request latch; the first frame
// byte then goes through the output register. Throughput: one ROM step per frame byte,
// one byte per cycle while m_tready holds; the next request is taken with the last byte.
// Output stalls hold the step counter. Reset: synchronous active-low aresetn clears
// control state, sequence number to 0, IDs to 1, CRC to 0xFFFF; no clearing pass.
module arm_command_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] arm, [1] force_req, [7:2] zero
    // frame byte channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_position, [15:14] zero
    output logic        m_tlast,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import acfb_pkg::*;

    logic [7:0]        sysid_reg;
    logic [7:0]        compid_reg;
    logic [7:0]        seq_reg;
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic              arm_reg;
    logic              force_reg;
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic [STEP_W-1:0] m_pos_reg;
    logic              m_last_reg;

    uword_t     uw;
    crc_ctl_t   crc_ctl;
    logic [15:0] crc;
    logic [7:0] byte_val;
    logic       advance;
    logic       s_accept;
    logic       cfg_wr;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_COMPID) ? {24'h0, compid_reg} : {24'h0, sysid_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sysid_reg  <= 8'd1;
            compid_reg <= 8'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SYSID) begin
                sysid_reg <= pwdata[7:0];
            end else begin
                compid_reg <= pwdata[7:0];
            end
        end
    end

    // microcode fetch and byte datapath
    assign uw = ucode(step_reg);

    always_comb begin
        case (uw.src)
            SRC_LIT:    byte_val = uw.lit;
            SRC_SEQ:    byte_val = seq_reg;
            SRC_SYSID:  byte_val = sysid_reg;
            SRC_COMPID: byte_val = compid_reg;
            SRC_ARM:    byte_val = arm_reg ? uw.lit : 8'h00;
            SRC_FORCE:  byte_val = force_reg ? uw.lit : 8'h00;
            SRC_CRC_LO: byte_val = crc[7:0];
            SRC_CRC_HI: byte_val = crc[15:8];
            default:    byte_val = 8'h00;
        endcase
    end

    // step when the output register is free or draining
    assign advance  = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready = !busy_reg || (advance && uw.fin);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        crc_ctl.init  = advance && uw.crc.init;
        crc_ctl.en    = advance && uw.crc.en;
        crc_ctl.extra = uw.crc.extra;
    end

    acfb_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .data    (byte_val),
        .crc     (crc)
    );

    // sequencer control; a new request restarts the program at step 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            seq_reg  <= 8'd0;
        end else begin
            if (advance && uw.fin) begin
                seq_reg <= seq_reg + 8'd1;
            end
            if (s_accept) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (advance) begin
                if (uw.fin) begin
                    busy_reg <= 1'b0;
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            arm_reg   <= s_tdata[0];
            force_reg <= s_tdata[1];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_byte_reg <= byte_val;
            m_pos_reg  <= step_reg;
            m_last_reg <= uw.fin;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

    // checks
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_pos_reg == STEP_W'(FRAME_LEN - 1))
        else $error("tlast not on final frame byte");

    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> step_reg == '0)
        else $error("step counter not parked while idle");

    a_pos_track: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_pos_reg == $past(step_reg))
        else $error("byte position does not follow the step");

    a_accept_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && busy_reg |-> uw.fin)
        else $error("request taken in mid-frame");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg && $stable(m_byte_reg))
        else $error("stalled frame byte lost");

endmodule
